// ----- hdl/texture_page_cache_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Texture page cache allocator assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_PAGE_CACHE_ALLOCATOR_DEFINES_SVH
`define TEXTURE_PAGE_CACHE_ALLOCATOR_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TPCA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define TPCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tpca_pkg.sv -----
// ----------------------------------------------------------------------------
// Texture page cache allocator package
// Shared constants, table row layout, sequencer states and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package tpca_pkg;

  localparam int unsigned PAGE_COUNT = 32;
  localparam int unsigned HALF_ROWS  = 128;
  localparam int unsigned PAGE_W     = $clog2(PAGE_COUNT);

  localparam logic [4:0] DYN_FIRST_RST = 5'd24;
  localparam logic [4:0] DYN_LAST_RST  = 5'd26;

  localparam logic [7:0] CNT_LOCKED = 8'd255;
  localparam logic [7:0] CNT_MAX    = 8'd254;
  localparam logic [7:0] Y_HALF1    = 8'(HALF_ROWS);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic CFG_DYN_FIRST = 1'b0;
  localparam logic CFG_DYN_LAST  = 1'b1;

  typedef enum logic [2:0] {
    STAT_HIT       = 3'd0,
    STAT_ALLOC     = 3'd1,
    STAT_NO_SPACE  = 3'd2,
    STAT_FREED     = 3'd3,
    STAT_RELEASED  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEARCH,
    ST_PLACE,
    ST_ALLOC,
    ST_FREE,
    ST_RESULT
  } state_e;

  typedef enum logic [1:0] {
    MODE_FIXED,
    MODE_HALF,
    MODE_WHOLE
  } mode_e;

  // One page: both halves side by side.
  typedef struct packed {
    logic [1:0][7:0]  cnt;
    logic [1:0][15:0] key;
    logic [1:0][4:0]  ofs;
  } row_t;

  typedef struct packed {
    logic [1:0]      hit;
    logic [1:0]      zero;
    logic [1:0]      locked;
    logic [1:0][7:0] inc;
    logic [1:0][7:0] dec;
  } eval_t;

  typedef struct packed {
    logic              rd_en;
    logic [PAGE_W-1:0] rd_page;
    logic              wr_en;
    logic [PAGE_W-1:0] wr_page;
    row_t              wr_row;
  } tbl_req_t;

  typedef struct packed {
    logic [4:0] page;
    logic       half;
    logic [4:0] x_ofs;
    status_e    status;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/tpca_eval.sv -----
// ----------------------------------------------------------------------------
// Texture page cache row evaluator
// Shared compare and count unit applied to one table row per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tpca_eval (
  input  tpca_pkg::row_t  row_i,
  input  logic [15:0]     key_i,
  output tpca_pkg::eval_t eval_o
);

  always_comb begin
    eval_o = '0;
    for (int h = 0; h < 2; h++) begin
      eval_o.hit[h]    = (row_i.key[h] == key_i);
      eval_o.zero[h]   = (row_i.cnt[h] == 8'd0);
      eval_o.locked[h] = (row_i.cnt[h] == tpca_pkg::CNT_LOCKED);
      // Saturate at the maximum and keep a lock mark as it is.
      eval_o.inc[h]    = (row_i.cnt[h] >= tpca_pkg::CNT_MAX) ? row_i.cnt[h]
                                                             : row_i.cnt[h] + 8'd1;
      eval_o.dec[h]    = row_i.cnt[h] - 8'd1;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tpca_table.sv -----
// ----------------------------------------------------------------------------
// Texture page cache table
// One row per page, one read and one write port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tpca_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpca_pkg::tbl_req_t req_i,
  output tpca_pkg::row_t     rd_row_o
);

  tpca_pkg::row_t                  mem_q [tpca_pkg::PAGE_COUNT];
  logic [tpca_pkg::PAGE_COUNT-1:0] valid_q;
  tpca_pkg::row_t                  rd_row_q;

  // A row never written reads as all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_page] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_page] <= req_i.wr_row;
    end
    if (req_i.rd_en) begin
      rd_row_q <= valid_q[req_i.rd_page] ? mem_q[req_i.rd_page] : '0;
    end
  end

  assign rd_row_o = rd_row_q;

endmodule

`default_nettype wire

// ----- hdl/tpca_ctrl.sv -----
// ----------------------------------------------------------------------------
// Texture page cache sequencer
// Walks the table one page a cycle for search and scans; a free reads one page.
// ----------------------------------------------------------------------------
`default_nettype none

module tpca_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_acc_i,
  input  logic               command_i,
  input  logic [15:0]        name_key_i,
  input  logic [4:0]         start_page_i,
  input  logic [8:0]         image_rows_i,
  input  logic [4:0]         free_page_i,
  input  logic               free_half_i,
  input  logic               invalidate_i,
  input  logic [4:0]         dyn_first_i,
  input  logic [4:0]         dyn_last_i,
  input  logic               out_free_i,
  input  tpca_pkg::row_t     rd_row_i,
  output tpca_pkg::tbl_req_t tbl_req_o,
  output logic               busy_o,
  output logic               res_load_o,
  output tpca_pkg::res_t     res_o
);

  tpca_pkg::state_e state_q, state_d;
  tpca_pkg::mode_e  mode_q, mode_d;
  logic [tpca_pkg::PAGE_W-1:0] ptr_q, ptr_d;
  tpca_pkg::res_t   res_q, res_d;

  logic        cmd_q;
  logic [15:0] key_q;
  logic [4:0]  start_q;
  logic [8:0]  rows_q;
  logic [4:0]  fpage_q;
  logic        fhalf_q;
  logic        inval_q;

  tpca_pkg::eval_t ev;
  tpca_pkg::row_t  row_w;

  logic [tpca_pkg::PAGE_W:0] nxt;
  logic       srch_last;
  logic       hit;
  logic       hit_h;
  logic       free_h;
  logic       scan_busy;
  logic       nxt_ok;
  logic       start_oor;
  logic       fpage_oor;
  logic       dyn;
  logic [4:0] ptr_page;
  logic [4:0] pofs;

  tpca_eval u_eval (
    .row_i  (rd_row_i),
    .key_i  (key_q),
    .eval_o (ev)
  );

  // Hold the item for the whole walk.
  always_ff @(posedge clk_i) begin
    if (in_acc_i) begin
      cmd_q   <= command_i;
      key_q   <= name_key_i;
      start_q <= start_page_i;
      rows_q  <= image_rows_i;
      fpage_q <= free_page_i;
      fhalf_q <= free_half_i;
      inval_q <= invalidate_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpca_pkg::ST_IDLE;
      mode_q  <= tpca_pkg::MODE_FIXED;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign nxt       = (tpca_pkg::PAGE_W + 1)'(ptr_q) + (tpca_pkg::PAGE_W + 1)'(1);
  assign srch_last = (ptr_q == (tpca_pkg::PAGE_W)'(tpca_pkg::PAGE_COUNT - 1));
  assign hit       = ev.hit[0] | ev.hit[1];
  assign hit_h     = ~ev.hit[0];
  assign free_h    = ~ev.zero[0];
  assign start_oor = (32'(start_q) >= 32'(tpca_pkg::PAGE_COUNT));
  assign fpage_oor = (32'(fpage_q) >= 32'(tpca_pkg::PAGE_COUNT));
  assign dyn       = (start_q >= dyn_first_i) && (start_q <= dyn_last_i);
  assign ptr_page  = 5'(ptr_q);
  assign pofs      = ptr_page - start_q;

  always_comb begin
    case (mode_q)
      tpca_pkg::MODE_HALF:  scan_busy = ~ev.zero[0] & ~ev.zero[1];
      tpca_pkg::MODE_WHOLE: scan_busy = ~ev.zero[0] | ~ev.zero[1];
      default:              scan_busy = 1'b0;
    endcase
    nxt_ok = (nxt < (tpca_pkg::PAGE_W + 1)'(tpca_pkg::PAGE_COUNT)) &&
             ((mode_q != tpca_pkg::MODE_HALF) || (32'(nxt) <= 32'(dyn_last_i)));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpca_pkg::ST_IDLE: begin
        if (in_acc_i) state_d = tpca_pkg::ST_DISPATCH;
      end
      tpca_pkg::ST_DISPATCH: begin
        if (cmd_q == tpca_pkg::CMD_FREE) begin
          state_d = fpage_oor ? tpca_pkg::ST_RESULT : tpca_pkg::ST_FREE;
        end else begin
          state_d = (key_q != 16'd0) ? tpca_pkg::ST_SEARCH : tpca_pkg::ST_PLACE;
        end
      end
      tpca_pkg::ST_SEARCH: begin
        if (hit) state_d = tpca_pkg::ST_RESULT;
        else if (srch_last) state_d = tpca_pkg::ST_PLACE;
      end
      tpca_pkg::ST_PLACE: begin
        state_d = start_oor ? tpca_pkg::ST_RESULT : tpca_pkg::ST_ALLOC;
      end
      tpca_pkg::ST_ALLOC: begin
        if (!(scan_busy && nxt_ok)) state_d = tpca_pkg::ST_RESULT;
      end
      tpca_pkg::ST_FREE: begin
        state_d = tpca_pkg::ST_RESULT;
      end
      tpca_pkg::ST_RESULT: begin
        if (out_free_i) state_d = tpca_pkg::ST_IDLE;
      end
      default: state_d = tpca_pkg::ST_IDLE;
    endcase
  end

  // Table requests, row updates and result.
  always_comb begin
    tbl_req_o = '0;
    row_w     = rd_row_i;
    ptr_d     = ptr_q;
    mode_d    = mode_q;
    res_d     = res_q;
    unique case (state_q)
      tpca_pkg::ST_IDLE: ;
      tpca_pkg::ST_DISPATCH: begin
        if (cmd_q == tpca_pkg::CMD_FREE) begin
          if (fpage_oor) begin
            res_d = '{page: fpage_q, half: fhalf_q, x_ofs: 5'd0,
                      status: tpca_pkg::STAT_FREED};
          end else begin
            tbl_req_o.rd_en   = 1'b1;
            tbl_req_o.rd_page = (tpca_pkg::PAGE_W)'(fpage_q);
          end
        end else if (key_q != 16'd0) begin
          // Page 0 never hits: start the search at page 1.
          tbl_req_o.rd_en   = 1'b1;
          tbl_req_o.rd_page = (tpca_pkg::PAGE_W)'(1);
          ptr_d             = (tpca_pkg::PAGE_W)'(1);
        end
      end
      tpca_pkg::ST_SEARCH: begin
        if (hit) begin
          row_w.cnt[hit_h]  = ev.inc[hit_h];
          tbl_req_o.wr_en   = 1'b1;
          res_d = '{page: ptr_page, half: hit_h, x_ofs: rd_row_i.ofs[hit_h],
                    status: tpca_pkg::STAT_HIT};
        end else if (!srch_last) begin
          tbl_req_o.rd_en   = 1'b1;
          tbl_req_o.rd_page = (tpca_pkg::PAGE_W)'(nxt);
          ptr_d             = (tpca_pkg::PAGE_W)'(nxt);
        end
      end
      tpca_pkg::ST_PLACE: begin
        if (start_oor) begin
          res_d = '{page: start_q, half: 1'b0, x_ofs: 5'd0,
                    status: tpca_pkg::STAT_NO_SPACE};
        end else begin
          tbl_req_o.rd_en   = 1'b1;
          tbl_req_o.rd_page = (tpca_pkg::PAGE_W)'(start_q);
          ptr_d             = (tpca_pkg::PAGE_W)'(start_q);
          if (!dyn) begin
            mode_d = tpca_pkg::MODE_FIXED;
          end else if (32'(rows_q) <= 32'(tpca_pkg::HALF_ROWS)) begin
            mode_d = tpca_pkg::MODE_HALF;
          end else begin
            mode_d = tpca_pkg::MODE_WHOLE;
          end
        end
      end
      tpca_pkg::ST_ALLOC: begin
        if (scan_busy) begin
          if (nxt_ok) begin
            tbl_req_o.rd_en   = 1'b1;
            tbl_req_o.rd_page = (tpca_pkg::PAGE_W)'(nxt);
            ptr_d             = (tpca_pkg::PAGE_W)'(nxt);
          end else begin
            res_d = '{page: start_q, half: 1'b0, x_ofs: 5'd0,
                      status: tpca_pkg::STAT_NO_SPACE};
          end
        end else begin
          tbl_req_o.wr_en = 1'b1;
          case (mode_q)
            tpca_pkg::MODE_HALF: begin
              row_w.cnt[free_h] = ev.inc[free_h];
              row_w.key[free_h] = key_q;
              row_w.ofs[free_h] = pofs;
              res_d = '{page: ptr_page, half: free_h, x_ofs: pofs,
                        status: tpca_pkg::STAT_ALLOC};
            end
            tpca_pkg::MODE_WHOLE: begin
              // Lock the second half for the whole page.
              row_w.cnt[1] = tpca_pkg::CNT_LOCKED;
              row_w.key[1] = 16'd0;
              row_w.cnt[0] = ev.inc[0];
              row_w.key[0] = key_q;
              row_w.ofs[0] = pofs;
              res_d = '{page: ptr_page, half: 1'b0, x_ofs: pofs,
                        status: tpca_pkg::STAT_ALLOC};
            end
            default: begin
              row_w.cnt[0] = ev.inc[0];
              row_w.key[0] = key_q;
              row_w.ofs[0] = pofs;
              res_d = '{page: ptr_page, half: 1'b0, x_ofs: pofs,
                        status: tpca_pkg::STAT_ALLOC};
            end
          endcase
        end
      end
      tpca_pkg::ST_FREE: begin
        res_d = '{page: fpage_q, half: fhalf_q, x_ofs: 5'd0,
                  status: tpca_pkg::STAT_FREED};
        if (!ev.zero[fhalf_q] && !ev.locked[fhalf_q]) begin
          tbl_req_o.wr_en       = 1'b1;
          row_w.cnt[fhalf_q]    = ev.dec[fhalf_q];
          if (ev.dec[fhalf_q] == 8'd0) begin
            if (inval_q) row_w.key[fhalf_q] = 16'd0;
            if (!fhalf_q && ev.locked[1]) row_w.cnt[1] = 8'd0;
            res_d.status = tpca_pkg::STAT_RELEASED;
          end
        end
      end
      tpca_pkg::ST_RESULT: ;
      default: ;
    endcase
    tbl_req_o.wr_page = ptr_q;
    if (state_q == tpca_pkg::ST_FREE) tbl_req_o.wr_page = (tpca_pkg::PAGE_W)'(fpage_q);
    tbl_req_o.wr_row  = row_w;
  end

  assign busy_o     = (state_q != tpca_pkg::ST_IDLE);
  assign res_load_o = (state_q == tpca_pkg::ST_RESULT) && out_free_i;
  assign res_o      = res_q;

endmodule

`default_nettype wire

// ----- hdl/texture_page_cache_allocator.sv -----
// ----------------------------------------------------------------------------
// Texture page cache allocator
// Reference-counted page/half allocation table with name lookup and free.
// ----------------------------------------------------------------------------
// Input beats (command, name key, start page, image rows, free page/half,
// invalidate) are taken on in_valid_i with in_stall_o low. One result beat
// per input beat leaves on out_valid_o and is taken when out_stall_i is low.
// The config port (cfg_valid_i/cfg_ready_o, always ready) writes register 0
// (dynamic first page) or 1 (dynamic last page); write it only while idle.
// One table row (one page) is read per cycle through a single compare unit;
// that row read sets the rate. A free reads only its own page and may write it
// back. A load first walks pages 1 to 31 for its name and stops at a hit; on
// a miss it then places the image, and a zero name skips that walk. A dynamic
// scan skips up to PAGE_COUNT - 1 busy pages before it places or gives up.
// The next beat is taken the cycle after the result is loaded into the output
// register, so a stalled receiver holds one result and blocks the next one.
// Reset clears the table (every count, name and offset reads as zero),
// restores the range registers to 24 and 26, and empties the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_page_cache_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [15:0] name_key_i,
  input  logic [4:0]  start_page_i,
  input  logic [8:0]  image_rows_i,
  input  logic [4:0]  free_page_i,
  input  logic        free_half_i,
  input  logic        invalidate_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  page_o,
  output logic        half_o,
  output logic [4:0]  x_offset_o,
  output logic [7:0]  y_offset_o,
  output logic [2:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

`include "texture_page_cache_allocator_defines.svh"

  logic [4:0] dyn_first_q;
  logic [4:0] dyn_last_q;

  logic               in_acc;
  logic               busy;
  logic               out_free;
  logic               res_load;
  tpca_pkg::res_t     res;
  tpca_pkg::tbl_req_t tbl_req;
  tpca_pkg::row_t     rd_row;

  logic           out_valid_q;
  tpca_pkg::res_t out_res_q;

  // Range registers; the port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dyn_first_q <= tpca_pkg::DYN_FIRST_RST;
      dyn_last_q  <= tpca_pkg::DYN_LAST_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tpca_pkg::CFG_DYN_FIRST: dyn_first_q <= cfg_data_i;
        tpca_pkg::CFG_DYN_LAST:  dyn_last_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Take a new beat only while the sequencer is idle.
  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  tpca_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (tbl_req),
    .rd_row_o (rd_row)
  );

  tpca_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_acc_i     (in_acc),
    .command_i    (command_i),
    .name_key_i   (name_key_i),
    .start_page_i (start_page_i),
    .image_rows_i (image_rows_i),
    .free_page_i  (free_page_i),
    .free_half_i  (free_half_i),
    .invalidate_i (invalidate_i),
    .dyn_first_i  (dyn_first_q),
    .dyn_last_i   (dyn_last_q),
    .out_free_i   (out_free),
    .rd_row_i     (rd_row),
    .tbl_req_o    (tbl_req),
    .busy_o       (busy),
    .res_load_o   (res_load),
    .res_o        (res)
  );

  // Output register: load a finished result when the slot is empty or
  // being drained this cycle; hold it while the receiver stalls.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign page_o      = out_res_q.page;
  assign half_o      = out_res_q.half;
  assign x_offset_o  = out_res_q.x_ofs;
  assign y_offset_o  = out_res_q.half ? tpca_pkg::Y_HALF1 : 8'd0;
  assign status_o    = out_res_q.status;

  // A result is never loaded in the cycle a new beat is accepted.
  `TPCA_ASSERT_SAME(a_load_vs_accept, res_load, !in_acc, "result load during accept")
  // A held result is never overwritten.
  `TPCA_ASSERT_SAME(a_hold_result, out_valid_q && out_stall_i, !res_load, "held result lost")
  // Table writes and reads never share a cycle.
  `TPCA_ASSERT_SAME(a_tbl_port, tbl_req.wr_en, !tbl_req.rd_en, "table read during write")
  // The sequencer is busy right after an accept.
  `TPCA_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o, "not busy after accept")

endmodule

`default_nettype wire

// ----- tb/tb_texture_page_cache_allocator.sv -----
// ----------------------------------------------------------------------------
// Texture page cache allocator testbench
// Drives load and free beats through the valid/stall input channel and checks
// every result beat against a typed-in expectation or a page-table predictor
// kept inside this bench. A short directed table runs first, then random
// phases under different dynamic-range settings, a long count-saturation
// burst, and back-pressure from both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_texture_page_cache_allocator;

  import tpca_pkg::*;

  localparam int unsigned ENTRIES         = 2 * PAGE_COUNT;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  // Worst correct gap between two beats is a full miss scan plus idle draws
  // on both sides; the long hold-off dominates, so allow far more.
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 80;
  localparam int unsigned SAT_BEATS       = 260;

  typedef struct packed {
    logic        command;
    logic [15:0] name_key;
    logic [4:0]  start_page;
    logic [8:0]  image_rows;
    logic [4:0]  free_page;
    logic        free_half;
    logic        invalidate;
  } request_t;

  typedef struct packed {
    logic [4:0] page;
    logic       half;
    logic [4:0] x_ofs;
    logic [7:0] y_ofs;
    status_e    status;
  } placement_t;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_FREE,
    ROW_RANGE
  } row_kind_e;

  // One directed step. For ROW_RANGE, page is the first dynamic page and last
  // the last one. Where typed is set, the expected result is given inline.
  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] key;
    logic [4:0]  page;
    logic [8:0]  rows;
    logic        half;
    logic        inval;
    logic [4:0]  last;
    logic        typed;
    logic [4:0]  exp_page;
    logic        exp_half;
    logic [4:0]  exp_x;
    status_e     exp_status;
  } table_row_t;

  localparam table_row_t DIRECTED_ROWS [24] = '{
    // kind      key       page   rows    half  inval last   typed pg     hf    x     status
    // frees on an empty table change nothing
    '{ROW_FREE,  16'h0000, 5'd0,  9'd0,   1'b0, 1'b0, 5'd0,  1'b1, 5'd0,  1'b0, 5'd0, STAT_FREED},
    '{ROW_FREE,  16'h0000, 5'd31, 9'd0,   1'b1, 1'b1, 5'd0,  1'b1, 5'd31, 1'b1, 5'd0, STAT_FREED},
    // fixed placement outside the dynamic range; page 0 is never a hit
    '{ROW_LOAD,  16'h0001, 5'd0,  9'd1,   1'b0, 1'b0, 5'd0,  1'b1, 5'd0,  1'b0, 5'd0, STAT_ALLOC},
    '{ROW_LOAD,  16'h0001, 5'd5,  9'd256, 1'b0, 1'b0, 5'd0,  1'b1, 5'd5,  1'b0, 5'd0, STAT_ALLOC},
    '{ROW_LOAD,  16'h0001, 5'd7,  9'd1,   1'b0, 1'b0, 5'd0,  1'b1, 5'd5,  1'b0, 5'd0, STAT_HIT},
    // half-page scan fills page 24, then a whole page lands on 25
    '{ROW_LOAD,  16'hFFFF, 5'd24, 9'd128, 1'b0, 1'b0, 5'd0,  1'b1, 5'd24, 1'b0, 5'd0, STAT_ALLOC},
    '{ROW_LOAD,  16'h8000, 5'd24, 9'd128, 1'b0, 1'b0, 5'd0,  1'b1, 5'd24, 1'b1, 5'd0, STAT_ALLOC},
    '{ROW_LOAD,  16'h1234, 5'd24, 9'd129, 1'b0, 1'b0, 5'd0,  1'b1, 5'd25, 1'b0, 5'd1, STAT_ALLOC},
    '{ROW_LOAD,  16'h4321, 5'd25, 9'd1,   1'b0, 1'b0, 5'd0,  1'b0, 5'd0,  1'b0, 5'd0, STAT_HIT},
    // zero key never hits, and the second one finds the range full
    '{ROW_LOAD,  16'h0000, 5'd26, 9'd64,  1'b0, 1'b0, 5'd0,  1'b0, 5'd0,  1'b0, 5'd0, STAT_HIT},
    '{ROW_LOAD,  16'h0000, 5'd26, 9'd64,  1'b0, 1'b0, 5'd0,  1'b1, 5'd26, 1'b0, 5'd0,
      STAT_NO_SPACE},
    // free of the locked half is a no-op; freeing half 0 releases and unlocks
    '{ROW_FREE,  16'h0000, 5'd25, 9'd0,   1'b1, 1'b0, 5'd0,  1'b1, 5'd25, 1'b1, 5'd0, STAT_FREED},
    '{ROW_FREE,  16'h0000, 5'd25, 9'd0,   1'b0, 1'b1, 5'd0,  1'b1, 5'd25, 1'b0, 5'd0,
      STAT_RELEASED},
    '{ROW_LOAD,  16'h1234, 5'd3,  9'd100, 1'b0, 1'b0, 5'd0,  1'b0, 5'd0,  1'b0, 5'd0, STAT_HIT},
    // release without invalidate keeps the name, so it hits again
    '{ROW_FREE,  16'h0000, 5'd5,  9'd0,   1'b0, 1'b0, 5'd0,  1'b1, 5'd5,  1'b0, 5'd0, STAT_FREED},
    '{ROW_FREE,  16'h0000, 5'd5,  9'd0,   1'b0, 1'b0, 5'd0,  1'b1, 5'd5,  1'b0, 5'd0,
      STAT_RELEASED},
    '{ROW_LOAD,  16'h0001, 5'd9,  9'd1,   1'b0, 1'b0, 5'd0,  1'b0, 5'd0,  1'b0, 5'd0, STAT_HIT},
    // empty dynamic range: everything is a fixed placement
    '{ROW_RANGE, 16'h0000, 5'd27, 9'd0,   1'b0, 1'b0, 5'd0,  1'b0, 5'd0,  1'b0, 5'd0, STAT_HIT},
    '{ROW_LOAD,  16'h2222, 5'd27, 9'd256, 1'b0, 1'b0, 5'd0,  1'b1, 5'd27, 1'b0, 5'd0, STAT_ALLOC},
    // full range: scans run off the end of the table
    '{ROW_RANGE, 16'h0000, 5'd0,  9'd0,   1'b0, 1'b0, 5'd31, 1'b0, 5'd0,  1'b0, 5'd0, STAT_HIT},
    '{ROW_LOAD,  16'h3333, 5'd31, 9'd256, 1'b0, 1'b0, 5'd0,  1'b1, 5'd31, 1'b0, 5'd0, STAT_ALLOC},
    '{ROW_LOAD,  16'h3334, 5'd31, 9'd256, 1'b0, 1'b0, 5'd0,  1'b1, 5'd31, 1'b0, 5'd0,
      STAT_NO_SPACE},
    '{ROW_LOAD,  16'h3335, 5'd31, 9'd1,   1'b0, 1'b0, 5'd0,  1'b1, 5'd31, 1'b0, 5'd0,
      STAT_NO_SPACE},
    '{ROW_LOAD,  16'hAAAA, 5'd0,  9'd129, 1'b0, 1'b0, 5'd0,  1'b0, 5'd0,  1'b0, 5'd0, STAT_HIT}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        command_i;
  logic [15:0] name_key_i;
  logic [4:0]  start_page_i;
  logic [8:0]  image_rows_i;
  logic [4:0]  free_page_i;
  logic        free_half_i;
  logic        invalidate_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [4:0]  page_o;
  logic        half_o;
  logic [4:0]  x_offset_o;
  logic [7:0]  y_offset_o;
  logic [2:0]  status_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [4:0]  cfg_data_i;

  // Shadow page table, indexed by page*2+half.
  logic [7:0]  page_cnt [ENTRIES];
  logic [15:0] page_key [ENTRIES];
  logic [4:0]  page_ofs [ENTRIES];
  logic [4:0]  range_first;
  logic [4:0]  range_last;

  logic [15:0] key_pool [16];
  placement_t  pending_placements [$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  logic        no_idle = 1'b0;
  logic        hold_off_req = 1'b0;

  texture_page_cache_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .name_key_i   (name_key_i),
    .start_page_i (start_page_i),
    .image_rows_i (image_rows_i),
    .free_page_i  (free_page_i),
    .free_half_i  (free_half_i),
    .invalidate_i (invalidate_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .page_o       (page_o),
    .half_o       (half_o),
    .x_offset_o   (x_offset_o),
    .y_offset_o   (y_offset_o),
    .status_o     (status_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic placement_t make_placement(input logic [4:0] page, input logic half,
                                                input logic [4:0] x_ofs, input status_e status);
    placement_t res;
    res.page   = page;
    res.half   = half;
    res.x_ofs  = x_ofs;
    res.y_ofs  = half ? Y_HALF1 : 8'd0;
    res.status = status;
    return res;
  endfunction

  // Apply one accepted beat to the shadow table and return its result.
  function automatic placement_t resolve_request(input request_t r);
    int unsigned e;
    int unsigned p;
    logic        h;
    if (r.command == CMD_FREE) begin
      e = {r.free_page, r.free_half};
      // Empty and locked entries are left alone.
      if (page_cnt[e] == 8'd0 || page_cnt[e] == CNT_LOCKED)
        return make_placement(r.free_page, r.free_half, 5'd0, STAT_FREED);
      page_cnt[e] = page_cnt[e] - 8'd1;
      if (page_cnt[e] != 8'd0)
        return make_placement(r.free_page, r.free_half, 5'd0, STAT_FREED);
      if (r.invalidate)
        page_key[e] = 16'h0000;
      // Releasing half 0 of a whole page unlocks its partner.
      if (!r.free_half && page_cnt[e + 1] == CNT_LOCKED)
        page_cnt[e + 1] = 8'd0;
      return make_placement(r.free_page, r.free_half, 5'd0, STAT_RELEASED);
    end

    // Name lookup skips page 0; a zero key never matches.
    if (r.name_key != 16'h0000) begin
      for (int unsigned pg = 1; pg < PAGE_COUNT; pg++) begin
        for (int unsigned hf = 0; hf < 2; hf++) begin
          e = 2 * pg + hf;
          if (page_key[e] == r.name_key) begin
            // Saturating bump; a locked count sits above the ceiling and stays.
            if (page_cnt[e] < CNT_MAX)
              page_cnt[e] = page_cnt[e] + 8'd1;
            return make_placement(5'(pg), 1'(hf), page_ofs[e], STAT_HIT);
          end
        end
      end
    end

    p = r.start_page;
    h = 1'b0;
    if (r.start_page >= range_first && r.start_page <= range_last) begin
      if (r.image_rows <= HALF_ROWS) begin
        while (p < PAGE_COUNT && p <= range_last &&
               page_cnt[2 * p] != 8'd0 && page_cnt[2 * p + 1] != 8'd0)
          p++;
        if (p >= PAGE_COUNT || p > range_last)
          return make_placement(r.start_page, 1'b0, 5'd0, STAT_NO_SPACE);
        h = (page_cnt[2 * p] != 8'd0);
      end else begin
        while (p < PAGE_COUNT && (page_cnt[2 * p] != 8'd0 || page_cnt[2 * p + 1] != 8'd0))
          p++;
        if (p >= PAGE_COUNT)
          return make_placement(r.start_page, 1'b0, 5'd0, STAT_NO_SPACE);
        page_key[2 * p + 1] = 16'h0000;
        page_cnt[2 * p + 1] = CNT_LOCKED;
      end
    end

    // A fixed placement reuses half 0 of the start page even when it is busy.
    e = 2 * p + h;
    if (page_cnt[e] < CNT_MAX)
      page_cnt[e] = page_cnt[e] + 8'd1;
    page_key[e] = r.name_key;
    page_ofs[e] = 5'(p - r.start_page);
    return make_placement(5'(p), h, page_ofs[e], STAT_ALLOC);
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one beat after a random gap (none under no_idle) and hold it until taken. Queue either
  // the typed-in expectation or the predicted one.
  task automatic offer_beat(input request_t r, input logic use_typed, input placement_t typed);
    int unsigned gap;
    placement_t  predicted;
    gap = no_idle ? 0 : $urandom_range(7, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= r.command;
    name_key_i   <= r.name_key;
    start_page_i <= r.start_page;
    image_rows_i <= r.image_rows;
    free_page_i  <= r.free_page;
    free_half_i  <= r.free_half;
    invalidate_i <= r.invalidate;
    do @(posedge clk_i); while (in_stall_o);
    predicted = resolve_request(r);
    pending_placements.push_back(use_typed ? typed : predicted);
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_placements.size() != 0);
  endtask

  // Rewrite both range registers while the block is idle.
  task automatic program_range(input logic [4:0] first, input logic [4:0] last);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_DYN_FIRST;
    cfg_data_i  <= first;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_DYN_LAST;
    cfg_data_i  <= last;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    range_first = first;
    range_last  = last;
  endtask

  // One random phase under a given range. Most beats are loads with pooled
  // names and frees of live entries; the rest is noise.
  task automatic run_phase(input logic [4:0] first, input logic [4:0] last,
                           input int unsigned beats, input logic steady,
                           input logic pause_mid);
    request_t    r;
    int unsigned dice;
    int unsigned base;
    int unsigned idx;
    logic        found;
    program_range(first, last);
    no_idle = steady;
    for (int unsigned n = 0; n < beats; n++) begin
      if (pause_mid && n == beats / 2)
        drain_results();
      // Randomize every field, then shape the ones that matter.
      r.command    = CMD_LOAD;
      r.name_key   = 16'($urandom());
      r.start_page = 5'($urandom());
      r.image_rows = 9'($urandom_range(2 * HALF_ROWS, 1));
      r.free_page  = 5'($urandom());
      r.free_half  = 1'($urandom());
      r.invalidate = 1'($urandom());
      dice = $urandom_range(99, 0);
      if (dice < 45) begin
        case ($urandom_range(19, 0))
          0:       r.name_key = 16'h0000;
          1, 2, 3: ;
          default: r.name_key = key_pool[$urandom_range(15, 0)];
        endcase
        if (first <= last && $urandom_range(9, 0) < 7)
          r.start_page = 5'($urandom_range(last, first));
        case ($urandom_range(9, 0))
          0:             r.image_rows = $urandom_range(1, 0) ? 9'(HALF_ROWS) : 9'(HALF_ROWS + 1);
          1, 2, 3, 4, 5: r.image_rows = 9'($urandom_range(HALF_ROWS, 1));
          default:       r.image_rows = 9'($urandom_range(2 * HALF_ROWS, HALF_ROWS + 1));
        endcase
      end else if (dice < 85) begin
        // Free a live entry, found by scanning the shadow table from a random spot.
        r.command = CMD_FREE;
        base = $urandom_range(ENTRIES - 1, 0);
        found = 1'b0;
        for (int unsigned k = 0; k < ENTRIES && !found; k++) begin
          idx = (base + k) % ENTRIES;
          if (page_cnt[idx] != 8'd0 && page_cnt[idx] != CNT_LOCKED) begin
            found = 1'b1;
            r.free_page = 5'(idx >> 1);
            r.free_half = idx[0];
          end
        end
      end else begin
        r.command = 1'($urandom());
      end
      offer_beat(r, 1'b0, '0);
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  initial begin : stimulus
    table_row_t row;
    request_t   r;
    rst_ni = 1'b0;
    in_valid_i   <= 1'b0;
    command_i    <= CMD_LOAD;
    name_key_i   <= 16'h0000;
    start_page_i <= 5'd0;
    image_rows_i <= 9'd0;
    free_page_i  <= 5'd0;
    free_half_i  <= 1'b0;
    invalidate_i <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= CFG_DYN_FIRST;
    cfg_data_i   <= 5'd0;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      page_cnt[i] = 8'd0;
      page_key[i] = 16'h0000;
      page_ofs[i] = 5'd0;
    end
    range_first = DYN_FIRST_RST;
    range_last  = DYN_LAST_RST;
    // A small pool of names so that loads hit often.
    key_pool[0] = 16'hFFFF;
    key_pool[1] = 16'h0001;
    for (int i = 2; i < 16; i++)
      key_pool[i] = 16'($urandom_range(65535, 1));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table.
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_RANGE) begin
        program_range(row.page, row.last);
      end else begin
        r.command    = (row.kind == ROW_FREE) ? CMD_FREE : CMD_LOAD;
        r.name_key   = row.key;
        r.start_page = row.page;
        r.image_rows = row.rows;
        r.free_page  = row.page;
        r.free_half  = row.half;
        r.invalidate = row.inval;
        offer_beat(r, row.typed,
                   make_placement(row.exp_page, row.exp_half, row.exp_x, row.exp_status));
      end
    end

    // Random phases over several range settings, extremes included.
    run_phase(5'd24, 5'd26, 125, 1'b0, 1'b0);
    // Back up the input: the sink holds off for a long stretch in this phase.
    hold_off_req = 1'b1;
    run_phase(5'd0, 5'd31, 125, 1'b0, 1'b0);
    run_phase(5'd31, 5'd31, 125, 1'b1, 1'b1);
    run_phase(5'd0, 5'd0, 125, 1'b0, 1'b0);
    run_phase(5'd31, 5'd0, 100, 1'b0, 1'b0);

    // Saturate one count: keep loading the same name at a fixed page.
    r = '0;
    r.command    = CMD_LOAD;
    r.name_key   = 16'h7A5C;
    r.start_page = 5'd12;
    r.image_rows = 9'd40;
    for (int unsigned n = 0; n < SAT_BEATS; n++)
      offer_beat(r, 1'b0, '0);

    run_phase(5'd20, 5'd31, 125, 1'b0, 1'b0);
    run_phase(5'($urandom()), 5'($urandom()), 125, 1'b0, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_placements.size() == 0) begin
      $display("tb_texture_page_cache_allocator: clean");
    end else begin
      $display("tb_texture_page_cache_allocator: errors");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side
  // --------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned pause;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        // Hold the output long enough for the block to stall its input.
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        pause = no_idle ? 0 : $urandom_range(7, 0);
        if (pause != 0) begin
          out_stall_i <= 1'b1;
          repeat (pause) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  // Compare each result beat with the oldest expectation; track idle cycles.
  always @(posedge clk_i) begin : result_check
    placement_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_placements.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: page %0d half %0d status %0d",
                   page_o, half_o, status_o);
      end else begin
        want = pending_placements.pop_front();
        check_field("page", 16'(want.page), 16'(page_o));
        check_field("half", 16'(want.half), 16'(half_o));
        check_field("x_offset", 16'(want.x_ofs), 16'(x_offset_o));
        check_field("y_offset", 16'(want.y_ofs), 16'(y_offset_o));
        check_field("status", 16'(want.status), 16'(status_o));
      end
    end
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // End the run if no beat moves on any channel for too long.
  initial begin : watchdog
    do @(posedge clk_i); while (quiet_cycles < STALL_LIMIT);
    $display("tb_texture_page_cache_allocator: errors");
    $finish;
  end

endmodule

`default_nettype wire
